// File: rtl/grid_voxel_traversal_macros.svh
// assertion helpers for the voxel traversal block
`ifndef GRID_VOXEL_TRAVERSAL_MACROS_SVH
`define GRID_VOXEL_TRAVERSAL_MACROS_SVH

// checked on every clock edge outside reset
`define GVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define GVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/gvt_pkg.sv
package gvt_pkg;

    localparam int MAX_CELLS = 16;
    localparam int FRAC_BITS = 12;
    localparam int ENTRY_W   = 16;
    localparam int STEP_W    = 24;
    localparam int SIGN_W    = 2;
    localparam int T_W       = 30;
    localparam int IDX_W     = 12;
    localparam int CFG_W     = 5;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int NCNT_W    = $clog2(MAX_CELLS + 1);
    localparam int STRIDE_W  = 2 * NCNT_W;
    localparam int DIST_W    = ENTRY_W + 1;
    localparam int PROD_W    = DIST_W + STEP_W;
    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = $clog2(NUM_AXES);
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [T_W-1:0] TMAX = {T_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_STEP
    } t_state;

    typedef enum logic [1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_CELLS_Z = 2'd2
    } t_reg_idx;

    typedef enum logic [AXIS_W-1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic any_move;
        logic exit_now;
    } t_stat;

    // cells in use: zero acts as one, anything above the grid size is clipped
    function automatic logic [NCNT_W-1:0] eff_cells(input logic [CFG_W-1:0] v);
        logic [NCNT_W-1:0] res;
        if (v == '0) begin
            res = NCNT_W'(1);
        end else if (v > CFG_W'(MAX_CELLS)) begin
            res = NCNT_W'(MAX_CELLS);
        end else begin
            res = NCNT_W'(v);
        end
        return res;
    endfunction

endpackage

// File: rtl/grid_voxel_traversal.sv
// 3D voxel walk of one ray through a grid of up to 16 cells per axis. A ray is taken
// when start is high and busy is low; the number of cells it crosses is at most
// cells_x + cells_y + cells_z - 2. The ray is latched and its start cell found as it
// is taken, the setup state then forms the first boundary times with one multiplier
// per axis, and the stepping loop compares the three pending times and emits one cell
// per cycle. Each cell appears on the result ports for exactly one cycle, marked by
// o_valid, and must be taken then: the receiver cannot stall. A ray with all signs zero
// gives no result. The grid size registers sit on the APB port; the user must write
// them only while busy is low, and the block itself does not enforce this.
module grid_voxel_traversal
    import gvt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ENTRY_W-1:0]        i_entry_x,
    input  logic [ENTRY_W-1:0]        i_entry_y,
    input  logic [ENTRY_W-1:0]        i_entry_z,
    input  logic signed [SIGN_W-1:0]  i_sign_x,
    input  logic signed [SIGN_W-1:0]  i_sign_y,
    input  logic signed [SIGN_W-1:0]  i_sign_z,
    input  logic [STEP_W-1:0]         i_step_t_x,
    input  logic [STEP_W-1:0]         i_step_t_y,
    input  logic [STEP_W-1:0]         i_step_t_z,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_cell_index,
    output logic [T_W-1:0]            o_t_exit,
    output logic [T_W-1:0]            o_seg_len,
    output logic                      o_last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    t_cmd              cmd;
    t_stat             stat;
    logic [NCNT_W-1:0] nx;
    logic [NCNT_W-1:0] ny;
    logic [NCNT_W-1:0] nz;

    gvt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_nx    (nx),
        .o_ny    (ny),
        .o_nz    (nz)
    );

    gvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gvt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_entry_x    (i_entry_x),
        .i_entry_y    (i_entry_y),
        .i_entry_z    (i_entry_z),
        .i_sign_x     (i_sign_x),
        .i_sign_y     (i_sign_y),
        .i_sign_z     (i_sign_z),
        .i_step_t_x   (i_step_t_x),
        .i_step_t_y   (i_step_t_y),
        .i_step_t_z   (i_step_t_z),
        .i_nx         (nx),
        .i_ny         (ny),
        .i_nz         (nz),
        .o_valid      (o_valid),
        .o_cell_index (o_cell_index),
        .o_t_exit     (o_t_exit),
        .o_seg_len    (o_seg_len),
        .o_last       (o_last)
    );

endmodule

// File: rtl/gvt_regs.sv
module gvt_regs
    import gvt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [NCNT_W-1:0]   o_nx,
    output logic [NCNT_W-1:0]   o_ny,
    output logic [NCNT_W-1:0]   o_nz
);

    logic [CFG_W-1:0] r_cells_x;
    logic [CFG_W-1:0] r_cells_y;
    logic [CFG_W-1:0] r_cells_z;
    logic             wr_en;
    t_reg_idx         reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CFG_W'(MAX_CELLS);
            r_cells_y <= CFG_W'(MAX_CELLS);
            r_cells_z <= CFG_W'(MAX_CELLS);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_CELLS_X: r_cells_x <= pwdata[CFG_W-1:0];
                REG_CELLS_Y: r_cells_y <= pwdata[CFG_W-1:0];
                REG_CELLS_Z: r_cells_z <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_CELLS_X: prdata = DATA_W'(r_cells_x);
            REG_CELLS_Y: prdata = DATA_W'(r_cells_y);
            REG_CELLS_Z: prdata = DATA_W'(r_cells_z);
            default:     prdata = '0;
        endcase
    end

    assign o_nx = eff_cells(r_cells_x);
    assign o_ny = eff_cells(r_cells_y);
    assign o_nz = eff_cells(r_cells_z);

endmodule

// File: rtl/gvt_ctrl.sv
module gvt_ctrl
    import gvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = i_stat.any_move ? ST_STEP : ST_IDLE;
            end
            ST_STEP: begin
                if (i_stat.exit_now) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != ST_IDLE);
        o_cmd.load  = (r_state == ST_IDLE) && start;
        o_cmd.setup = (r_state == ST_SETUP);
        o_cmd.step  = (r_state == ST_STEP);
    end

endmodule

// File: rtl/gvt_dp.sv
module gvt_dp
    import gvt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic [ENTRY_W-1:0]        i_entry_x,
    input  logic [ENTRY_W-1:0]        i_entry_y,
    input  logic [ENTRY_W-1:0]        i_entry_z,
    input  logic signed [SIGN_W-1:0]  i_sign_x,
    input  logic signed [SIGN_W-1:0]  i_sign_y,
    input  logic signed [SIGN_W-1:0]  i_sign_z,
    input  logic [STEP_W-1:0]         i_step_t_x,
    input  logic [STEP_W-1:0]         i_step_t_y,
    input  logic [STEP_W-1:0]         i_step_t_z,
    input  logic [NCNT_W-1:0]         i_nx,
    input  logic [NCNT_W-1:0]         i_ny,
    input  logic [NCNT_W-1:0]         i_nz,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_cell_index,
    output logic [T_W-1:0]            o_t_exit,
    output logic [T_W-1:0]            o_seg_len,
    output logic                      o_last
);

    logic [ENTRY_W-1:0]  entry_a  [NUM_AXES];
    logic [SIGN_W-1:0]   sign_a   [NUM_AXES];
    logic [STEP_W-1:0]   step_a   [NUM_AXES];
    logic [NCNT_W-1:0]   n_a      [NUM_AXES];
    logic [NCNT_W-1:0]   nm1_a    [NUM_AXES];
    logic [ENTRY_W-1:0]  ci_full  [NUM_AXES];
    logic [CELL_W-1:0]   ci_a     [NUM_AXES];
    logic [DIST_W-1:0]   ez_a     [NUM_AXES];
    logic [DIST_W-1:0]   edge_a   [NUM_AXES];
    logic [DIST_W-1:0]   base_a   [NUM_AXES];
    logic [DIST_W-1:0]   dist_a   [NUM_AXES];
    logic [PROD_W-1:0]   prod_a   [NUM_AXES];
    logic [PROD_W-1:0]   scaled_a [NUM_AXES];
    logic [T_W-1:0]      t_init_a [NUM_AXES];
    logic [IDX_W-1:0]    stride_a [NUM_AXES];

    logic [CELL_W-1:0]   r_c      [NUM_AXES];
    logic [NCNT_W-1:0]   r_nm1    [NUM_AXES];
    logic                r_neg    [NUM_AXES];
    logic                r_mv     [NUM_AXES];
    logic [STEP_W-1:0]   r_dt     [NUM_AXES];
    logic [DIST_W-1:0]   r_dist   [NUM_AXES];
    logic [T_W-1:0]      r_t      [NUM_AXES];
    logic [NCNT_W-1:0]   r_stride_y;
    logic [STRIDE_W-1:0] r_stride_z;
    logic [IDX_W-1:0]    r_idx;
    logic [T_W-1:0]      r_t_near;

    logic                r_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [T_W-1:0]      r_out_t;
    logic [T_W-1:0]      r_out_len;
    logic                r_out_last;

    logic [IDX_W-1:0]    idx_init;
    t_axis               sel;
    logic [T_W-1:0]      t_sel;
    logic [T_W-1:0]      seg_len;
    logic [T_W:0]        t_sum;
    logic [T_W-1:0]      t_next;
    logic                exit_now;
    logic                x_wins;
    logic                y_wins;

    assign entry_a[0] = i_entry_x;
    assign entry_a[1] = i_entry_y;
    assign entry_a[2] = i_entry_z;
    assign sign_a[0]  = i_sign_x;
    assign sign_a[1]  = i_sign_y;
    assign sign_a[2]  = i_sign_z;
    assign step_a[0]  = i_step_t_x;
    assign step_a[1]  = i_step_t_y;
    assign step_a[2]  = i_step_t_z;
    assign n_a[0]     = i_nx;
    assign n_a[1]     = i_ny;
    assign n_a[2]     = i_nz;

    // start cell and distance to the first boundary
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            nm1_a[a]   = n_a[a] - NCNT_W'(1);
            ci_full[a] = entry_a[a] >> FRAC_BITS;
            if (ci_full[a] > ENTRY_W'(nm1_a[a])) begin
                ci_a[a] = nm1_a[a][CELL_W-1:0];
            end else begin
                ci_a[a] = ci_full[a][CELL_W-1:0];
            end
            ez_a[a]   = DIST_W'(entry_a[a]);
            base_a[a] = DIST_W'(ci_a[a]) << FRAC_BITS;
            edge_a[a] = (DIST_W'(ci_a[a]) + DIST_W'(1)) << FRAC_BITS;
            if (sign_a[a][SIGN_W-1]) begin
                dist_a[a] = ez_a[a] - base_a[a];
            end else if (edge_a[a] > ez_a[a]) begin
                dist_a[a] = edge_a[a] - ez_a[a];
            end else begin
                dist_a[a] = '0;
            end
        end
    end

    // first boundary crossing time
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            prod_a[a]   = PROD_W'(r_dist[a]) * PROD_W'(r_dt[a]);
            scaled_a[a] = prod_a[a] >> FRAC_BITS;
            if (!r_mv[a] || (scaled_a[a] > PROD_W'(TMAX))) begin
                t_init_a[a] = TMAX;
            end else begin
                t_init_a[a] = scaled_a[a][T_W-1:0];
            end
        end
    end

    assign idx_init = IDX_W'(r_c[2]) * IDX_W'(r_stride_z)
                    + IDX_W'(r_c[1]) * IDX_W'(r_stride_y)
                    + IDX_W'(r_c[0]);

    assign stride_a[0] = IDX_W'(1);
    assign stride_a[1] = IDX_W'(r_stride_y);
    assign stride_a[2] = IDX_W'(r_stride_z);

    // axis with the nearest boundary, lower axis on a tie
    always_comb begin
        x_wins = r_mv[0] && (!r_mv[1] || (r_t[0] <= r_t[1]))
                         && (!r_mv[2] || (r_t[0] <= r_t[2]));
        y_wins = r_mv[1] && (!r_mv[2] || (r_t[1] <= r_t[2]));
        priority if (x_wins) begin
            sel = AX_X;
        end else if (y_wins) begin
            sel = AX_Y;
        end else begin
            sel = AX_Z;
        end
    end

    assign t_sel    = r_t[sel];
    assign seg_len  = t_sel - r_t_near;
    assign t_sum    = (T_W + 1)'(t_sel) + (T_W + 1)'(r_dt[sel]);
    assign t_next   = (t_sum > (T_W + 1)'(TMAX)) ? TMAX : t_sum[T_W-1:0];
    assign exit_now = r_neg[sel] ? (r_c[sel] == '0)
                                 : (NCNT_W'(r_c[sel]) == r_nm1[sel]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_c[a]    <= ci_a[a];
                r_nm1[a]  <= nm1_a[a];
                r_neg[a]  <= sign_a[a][SIGN_W-1];
                r_mv[a]   <= (sign_a[a] != '0);
                r_dt[a]   <= step_a[a];
                r_dist[a] <= dist_a[a];
            end
            r_stride_y <= i_nx;
            r_stride_z <= STRIDE_W'(i_nx) * STRIDE_W'(i_ny);
        end
        if (i_cmd.setup) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_t[a] <= t_init_a[a];
            end
            r_idx    <= idx_init;
            r_t_near <= '0;
        end
        if (i_cmd.step) begin
            r_t[sel] <= t_next;
            r_c[sel] <= r_neg[sel] ? (r_c[sel] - CELL_W'(1)) : (r_c[sel] + CELL_W'(1));
            r_idx    <= r_neg[sel] ? (r_idx - stride_a[sel]) : (r_idx + stride_a[sel]);
            r_t_near <= t_sel;
            r_out_idx  <= r_idx;
            r_out_t    <= t_sel;
            r_out_len  <= seg_len;
            r_out_last <= exit_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    assign o_stat.any_move = r_mv[0] || r_mv[1] || r_mv[2];
    assign o_stat.exit_now = exit_now;

    assign o_valid      = r_valid;
    assign o_cell_index = r_out_idx;
    assign o_t_exit     = r_out_t;
    assign o_seg_len    = r_out_len;
    assign o_last       = r_out_last;

endmodule

// File: rtl/gvt_checker.sv
`include "grid_voxel_traversal_macros.svh"

module gvt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last,
    input logic pready
);

    // results only come out of a ray in flight
    `GVT_ASSERT(a_valid_needs_busy, o_valid |-> $past(busy), "result without a ray in flight")

    // a taken item keeps the block busy for at least the setup cycle
    `GVT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "item taken but block not busy")

    // the cells of one ray come out back to back
    `GVT_ASSERT(a_no_gap, (o_valid && !o_last) |=> o_valid, "gap inside a ray's cell list")

    // a new ray needs setup before its first cell
    `GVT_ASSERT(a_gap_after_last, (o_valid && o_last) |=> !o_valid, "result right after last")

    `GVT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind grid_voxel_traversal gvt_checker u_gvt_checker (.*);
